// ===== hw/rtl/ier_pkg.sv =====
// Shared types and constants for the ICMP echo reply rewriter.
package ier_pkg;

    // Received byte stream item
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       rx_end;
    } t_rx_item;

    // Reply byte stream item
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_end;
        logic       reply_ok;
        logic       short_frame;
    } t_tx_item;

    // Configuration register indexes
    localparam logic [1:0] REG_OWN_MAC = 2'd0;
    localparam logic [1:0] REG_OWN_IP  = 2'd1;

    // Frame layout and protocol constants
    localparam logic [16:0] C_POS_MAX    = 17'h1FFFF;
    localparam logic [16:0] C_MIN_LEN    = 17'd38;
    localparam logic [16:0] C_ETH_HDR    = 17'd14;
    localparam logic [16:0] C_MAC_LAST   = 17'd11;
    localparam logic [16:0] C_SRC_MAC    = 17'd6;
    localparam logic [16:0] C_HDR_END    = 17'd18;
    localparam logic [16:0] C_LEN_HI     = 17'd16;
    localparam logic [16:0] C_LEN_LO     = 17'd17;
    localparam logic [16:0] C_SIP_FIRST  = 17'd26;
    localparam logic [16:0] C_SIP_LAST   = 17'd29;
    localparam logic [16:0] C_DIP_FIRST  = 17'd30;
    localparam logic [16:0] C_DIP_LAST   = 17'd33;
    localparam logic [16:0] C_ICMP_TYPE  = 17'd34;
    localparam logic [16:0] C_CSUM_HI    = 17'd36;
    localparam logic [16:0] C_CSUM_LO    = 17'd37;
    localparam logic [7:0]  C_ECHO_REQ   = 8'h08;
    localparam logic [7:0]  C_ECHO_REPLY = 8'h00;
    localparam logic [15:0] C_CSUM_ADJ   = 16'hF7FF;

    // Command queue between front and back
    localparam int C_QDEPTH = 4;
    localparam int C_QAW    = $clog2(C_QDEPTH);

    typedef enum logic [1:0] {
        CMD_BYTE,   // one byte: data[7:0]
        CMD_PAIR,   // two bytes: data[15:8], data[7:0]
        CMD_MAC     // twelve bytes: data[47:0], then own MAC
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [47:0] data;
        logic        last;     // final item of the reply frame
        logic        ok;
        logic        short_fr;
    } t_cmd;

endpackage

// ===== hw/rtl/ier_front.sv =====
// Front end: tracks frame position, holds header bytes, classifies each item and emits commands.
module ier_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  ier_pkg::t_rx_item i_rx,
    input  logic [31:0]      i_own_ip,
    output logic             o_cmd_valid,
    output ier_pkg::t_cmd    o_cmd
);
    import ier_pkg::*;

    logic [16:0] r_pos, n_pos;
    logic [16:0] r_len, n_len;
    logic [7:0]  r_csum_hi, n_csum_hi;
    logic        r_dest_match, n_dest_match;
    logic        r_is_req, n_is_req;
    logic [7:0]  r_mac_hold [5];
    logic [7:0]  r_sip_hold [4];

    logic [7:0]  b;
    logic [17:0] pos_inc;
    logic [16:0] lim;
    logic [1:0]  ip_k;
    logic [7:0]  ip_byte;
    logic [2:0]  mac_idx;
    logic [15:0] csum_x;
    logic [16:0] csum_sum;
    logic [15:0] csum_fold;
    logic        emit;
    logic        is_last;
    logic        early;
    t_cmd        cmd;

    assign b       = i_rx.rx_byte;
    assign pos_inc = {1'b0, r_pos} + 18'd1;
    assign lim     = (r_len < C_MIN_LEN) ? C_MIN_LEN : r_len;
    // IP byte lane: positions 26 and 30 map to lane 0
    assign ip_k    = r_pos[1:0] + 2'd2;
    assign ip_byte = 8'(i_own_ip >> {~ip_k, 3'b000});
    assign mac_idx = 3'(r_pos - C_SRC_MAC);

    // Checksum fix for type 0x08 -> 0x00, end-around carry
    assign csum_x    = ~{r_csum_hi, b};
    assign csum_sum  = {1'b0, csum_x} + {1'b0, C_CSUM_ADJ};
    assign csum_fold = csum_sum[15:0] + {15'd0, csum_sum[16]};

    always_comb begin
        n_pos        = r_pos;
        n_len        = r_len;
        n_csum_hi    = r_csum_hi;
        n_dest_match = r_dest_match;
        n_is_req     = r_is_req;
        emit         = 1'b0;
        cmd          = '{kind: CMD_BYTE, data: {40'd0, b}, last: 1'b0, ok: 1'b0,
                         short_fr: 1'b0};

        if (r_pos < 17'd12) begin
            if (r_pos == C_MAC_LAST) begin
                emit     = 1'b1;
                cmd.kind = CMD_MAC;
                cmd.data = {r_mac_hold[0], r_mac_hold[1], r_mac_hold[2],
                            r_mac_hold[3], r_mac_hold[4], b};
            end
        end else if (r_pos < C_HDR_END) begin
            emit = 1'b1;
            if (r_pos == C_LEN_HI) begin
                n_len = {1'b0, b, 8'd0};
            end else if (r_pos == C_LEN_LO) begin
                n_len = C_ETH_HDR + {1'b0, r_len[15:8], b};
            end
        end else if (r_pos < lim) begin
            emit = 1'b1;
            if (r_pos >= C_SIP_FIRST && r_pos <= C_SIP_LAST) begin
                cmd.data = {40'd0, ip_byte};
            end else if (r_pos >= C_DIP_FIRST && r_pos <= C_DIP_LAST) begin
                if (b != ip_byte) begin
                    n_dest_match = 1'b0;
                end
                cmd.data = {40'd0, r_sip_hold[ip_k]};
            end else if (r_pos == C_ICMP_TYPE) begin
                n_is_req = (b == C_ECHO_REQ);
                cmd.data = {40'd0, C_ECHO_REPLY};
            end else if (r_pos == C_CSUM_HI) begin
                emit      = 1'b0;
                n_csum_hi = b;
            end else if (r_pos == C_CSUM_LO) begin
                cmd.kind = CMD_PAIR;
                cmd.data = {32'd0, ~csum_fold};
            end
        end

        is_last = (r_pos >= C_HDR_END) && (pos_inc == {1'b0, lim});
        early   = i_rx.rx_end && ((r_pos < C_HDR_END) || (pos_inc < {1'b0, lim}));

        if (is_last) begin
            cmd.last = 1'b1;
            cmd.ok   = n_is_req & n_dest_match;
        end else if (early) begin
            if (!emit) begin
                // Nothing to send on this item: send a zero filler to close the frame
                emit     = 1'b1;
                cmd.kind = CMD_BYTE;
                cmd.data = '0;
            end
            cmd.last     = 1'b1;
            cmd.short_fr = 1'b1;
        end

        if (i_rx.rx_end) begin
            n_pos        = '0;
            n_len        = '0;
            n_csum_hi    = '0;
            n_dest_match = 1'b1;
            n_is_req     = 1'b0;
        end else if (r_pos != C_POS_MAX) begin
            n_pos = pos_inc[16:0];
        end
    end

    assign o_cmd_valid = i_accept && emit;
    assign o_cmd       = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_len        <= '0;
            r_csum_hi    <= '0;
            r_dest_match <= 1'b1;
            r_is_req     <= 1'b0;
        end else if (i_accept) begin
            r_pos        <= n_pos;
            r_len        <= n_len;
            r_csum_hi    <= n_csum_hi;
            r_dest_match <= n_dest_match;
            r_is_req     <= n_is_req;
        end
    end

    // Holding buffers, no reset
    always_ff @(posedge i_clk) begin
        if (i_accept && r_pos >= C_SRC_MAC && r_pos < C_MAC_LAST) begin
            r_mac_hold[mac_idx] <= b;
        end
        if (i_accept && r_pos >= C_SIP_FIRST && r_pos <= C_SIP_LAST) begin
            r_sip_hold[ip_k] <= b;
        end
    end

endmodule

// ===== hw/rtl/ier_fifo.sv =====
// Short command queue between the front and the back.
module ier_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ier_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output ier_pkg::t_cmd o_cmd
);
    import ier_pkg::*;

    t_cmd             r_mem [C_QDEPTH];
    logic [C_QAW-1:0] r_wr;
    logic [C_QAW-1:0] r_rd;
    logic [C_QAW:0]   r_cnt;

    assign o_full  = (r_cnt == (C_QAW+1)'(C_QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// ===== hw/rtl/ier_back.sv =====
// Back end: expands commands into reply bytes and drives the output register.
module ier_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  ier_pkg::t_cmd     i_q_cmd,
    output logic              o_q_pop,
    input  logic [47:0]       i_own_mac,
    input  logic              i_pop,
    output logic              o_empty,
    output ier_pkg::t_tx_item o_tx
);
    import ier_pkg::*;

    t_cmd      r_cur;
    logic      r_cur_v;
    logic [3:0] r_idx;
    t_tx_item  r_out;
    logic      r_out_v;

    logic       out_free;
    logic       fire;
    logic       done;
    logic       load;
    logic [3:0] last_idx;
    logic [95:0] seq;
    logic [95:0] seq_sh;
    logic       at_last;

    always_comb begin
        case (r_cur.kind)
            CMD_MAC: begin
                last_idx = 4'd11;
                seq      = {r_cur.data, i_own_mac};
            end
            CMD_PAIR: begin
                last_idx = 4'd1;
                seq      = {r_cur.data[15:0], 80'd0};
            end
            default: begin
                last_idx = 4'd0;
                seq      = {r_cur.data[7:0], 88'd0};
            end
        endcase
    end

    assign seq_sh   = seq << {r_idx, 3'b000};
    assign at_last  = (r_idx == last_idx);
    assign out_free = !r_out_v || i_pop;
    assign fire     = r_cur_v && out_free;
    assign done     = fire && at_last;
    assign load     = (!r_cur_v || done) && !i_q_empty;
    assign o_q_pop  = load;
    assign o_empty  = !r_out_v;
    assign o_tx     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_v <= 1'b0;
            r_idx   <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (load) begin
                r_cur_v <= 1'b1;
                r_idx   <= '0;
            end else if (done) begin
                r_cur_v <= 1'b0;
            end else if (fire) begin
                r_idx <= r_idx + 1'b1;
            end

            if (fire) begin
                r_out_v <= 1'b1;
            end else if (i_pop) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_q_cmd;
        end
        if (fire) begin
            r_out.tx_byte     <= seq_sh[95:88];
            r_out.tx_end      <= at_last && r_cur.last;
            r_out.reply_ok    <= at_last && r_cur.ok;
            r_out.short_frame <= at_last && r_cur.short_fr;
        end
    end

endmodule

// ===== hw/rtl/icmp_echo_reply_rewriter_top.sv =====
// Top level of the ICMP echo reply rewriter: config registers, front, queue, back.
//
// Usage:
// - Input channel: push/full. One received frame byte per item (i_rx.rx_byte),
//   with i_rx.rx_end on the final byte. An item is taken when push is high and
//   full is low.
// - Output channel: empty/pop. While empty is low the oldest reply byte is on
//   o_tx; pop takes it. tx_end marks the last reply byte, and on that byte
//   reply_ok says "echo request to our IP" and short_frame says the input ended
//   before the header, the stated IP length or the 38-byte minimum.
// - Config channel: i_cfg_valid/o_cfg_ready (always ready), i_cfg_index selects
//   own MAC (0) or own IP (1); other indexes are ignored. Write only when idle.
// Timing:
// - With the back end idle, a taken item's command passes through the command
//   queue and the current-command register before its first reply byte is registered.
// - One item per cycle is accepted while full is low; the back end emits one
//   byte per cycle while the output register is free. The twelve-byte MAC
//   burst at the twelfth input byte fills the four-entry command queue, so
//   with back-to-back input full is high while the burst drains.
// - When the receiver stalls, the output register holds and the queue fills;
//   full then stops the sender. Nothing is dropped.
// - Reset (synchronous, active low) clears the frame position, the queue, the
//   output register and both config registers; no clearing pass is needed.
module icmp_echo_reply_rewriter_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input byte stream
    input  logic              push,
    output logic              full,
    input  ier_pkg::t_rx_item i_rx,
    // reply byte stream
    output logic              empty,
    input  logic              pop,
    output ier_pkg::t_tx_item o_tx,
    // config writes
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [47:0]       i_cfg_data
);
    import ier_pkg::*;

    logic [47:0] r_own_mac;
    logic [31:0] r_own_ip;

    logic accept;
    logic cmd_valid;
    t_cmd cmd_in;
    t_cmd cmd_out;
    logic q_empty;
    logic q_pop;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac <= '0;
            r_own_ip  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_OWN_MAC: r_own_mac <= i_cfg_data;
                REG_OWN_IP:  r_own_ip  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Position tracking and per-byte classification
    ier_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx        (i_rx),
        .i_own_ip    (r_own_ip),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd_in)
    );

    // Decouples the bursty back end from the input
    ier_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (cmd_out)
    );

    // Byte generation and output register
    ier_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_cmd   (cmd_out),
        .o_q_pop   (q_pop),
        .i_own_mac (r_own_mac),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_tx      (o_tx)
    );

endmodule

// ===== hw/rtl/ier_checker.sv =====
// Port-level checks for the ICMP echo reply rewriter, bound to the top level.
module ier_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input ier_pkg::t_tx_item o_tx
);
    // Reset leaves the block with nothing to send and room for input
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("not idle after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_tx))
        else $error("result changed while stalled");

    // Status flags only on the last byte of a reply
    a_flags_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_tx.tx_end |-> !o_tx.reply_ok && !o_tx.short_frame)
        else $error("status flag set before end of reply");

    // A short frame is never a valid reply
    a_ok_not_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_tx.reply_ok && o_tx.short_frame))
        else $error("reply_ok with short_frame");

endmodule

bind icmp_echo_reply_rewriter_top ier_checker u_ier_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_tx    (o_tx)
);
